FILE: hdl/epbs_pkg.sv
// Shared types, constants and codes for the edge proximity beep scheduler.
package epbs_pkg;

   localparam int unsigned EPBS_QUEUE_DEPTH = 2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 13;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ONSET_FRACTION = 2'd0,
      CSR_ANTICIPATION   = 2'd1,
      CSR_INTERVAL_FAR   = 2'd2,
      CSR_INTERVAL_NEAR  = 2'd3
   } csr_index_type;

   localparam logic [12:0] ONSET_FRACTION_RESET = 13'd2048;
   localparam logic [10:0] ANTICIPATION_RESET   = 11'd500;
   localparam logic [10:0] INTERVAL_FAR_RESET   = 11'd450;
   localparam logic [10:0] INTERVAL_NEAR_RESET  = 11'd100;

   localparam logic [15:0] GRADE_ONSET   = 16'd4096;
   localparam logic [15:0] GRADE_RELEASE = 16'd3686;
   localparam logic [15:0] GRADE_STEP    = 16'd1024;
   localparam logic [15:0] GRADE_CEILING = 16'd6144;

   localparam logic [1:0] EDGE_UNKNOWN = 2'd0;
   localparam logic [1:0] EDGE_WALL    = 2'd1;
   localparam logic [1:0] EDGE_FALL    = 2'd2;
   localparam logic [1:0] EDGE_OTHER   = 2'd3;

   localparam logic [1:0] PAN_CENTRE = 2'd0;
   localparam logic [1:0] PAN_LEFT   = 2'd1;
   localparam logic [1:0] PAN_RIGHT  = 2'd2;

   localparam logic [9:0] TONE_HZ      = 10'd540;
   localparam logic [9:0] TONE_FALL_HZ = 10'd270;
   localparam logic [9:0] BEEP_HZ      = 10'd240;
   localparam logic [9:0] BEEP_FALL_HZ = 10'd120;

   // Divider geometry: dividend |P|*2048 below 2^54, divisor 1000*OM below 2^39.
   localparam int unsigned DIV_W = 57;
   localparam int unsigned QUO_W = 18;

   typedef struct packed {
      logic               off_road;
      logic               have_offset;
      logic signed [15:0] offset;
      logic        [15:0] corridor;
      logic               have_real;
      logic        [15:0] real_distance;
      logic        [1:0]  edge_kind;
      logic               pan_right;
      logic signed [15:0] closing_rate;
      logic        [9:0]  frame_ms;
   } req_type;

   typedef struct packed {
      logic       tone_hold;
      logic       tone_stop;
      logic       beep;
      logic       saw_wave;
      logic [9:0] frequency_hz;
      logic [1:0] pan;
      logic       near_edge;
   } rsp_type;

   typedef struct packed {
      logic [12:0] onset_fraction;
      logic [10:0] anticipation_ms;
      logic [10:0] interval_far_ms;
      logic [10:0] interval_near_ms;
   } cfg_type;

   typedef enum logic [1:0] {
      CLS_OFF_ROAD  = 2'd0,
      CLS_NO_OFFSET = 2'd1,
      CLS_CORRIDOR  = 2'd2,
      CLS_MEASURED  = 2'd3
   } cls_type;

   typedef struct packed {
      cls_type     cls;
      logic        measured;
      logic        fall;
      logic        no_tone_kind;
      logic [1:0]  off_pan;
      logic        pan_right;
      logic [15:0] mag;
      logic [15:0] corridor;
      logic [15:0] real_distance;
      logic [14:0] closing_pos;
      logic [9:0]  frame_ms;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MUL_OM,
      ST_MUL_MC,
      ST_MUL_M,
      ST_MUL_CA,
      ST_MUL_D,
      ST_DIV_INIT,
      ST_DIV,
      ST_GRADE,
      ST_APPLY,
      ST_INTV_A,
      ST_INTV_B,
      ST_DECIDE
   } state_type;

endpackage

FILE: hdl/epbs_front.sv
// Front end: accept frames and classify them into queue entries.
module epbs_front (
   input  logic               req_valid,
   input  epbs_pkg::req_type  req_data,
   output logic               req_stall,
   input  logic [12:0]        onset_fraction,
   input  logic               queue_full,
   output logic               push,
   output epbs_pkg::entry_type entry
);
   import epbs_pkg::*;

   logic       measured;
   logic [1:0] kind;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      measured = req_data.have_real && req_data.have_offset;
      kind     = measured ? req_data.edge_kind : EDGE_UNKNOWN;

      entry.measured     = measured;
      entry.fall         = (kind == EDGE_FALL);
      entry.no_tone_kind = (kind == EDGE_WALL) || (kind == EDGE_FALL);
      entry.pan_right    = req_data.pan_right;
      entry.mag          = req_data.offset[15] ? 16'(-req_data.offset)
                                               : 16'(req_data.offset);
      entry.corridor      = req_data.corridor;
      entry.real_distance = req_data.real_distance;
      entry.closing_pos   = (!req_data.closing_rate[15]) ? req_data.closing_rate[14:0]
                                                         : 15'd0;
      entry.frame_ms      = req_data.frame_ms;
      if (req_data.have_offset && (req_data.offset != 16'sd0)) begin
         entry.off_pan = req_data.pan_right ? PAN_RIGHT : PAN_LEFT;
      end else begin
         entry.off_pan = PAN_CENTRE;
      end

      // Zero onset margin falls back to the corridor grade.
      if (req_data.off_road) begin
         entry.cls = CLS_OFF_ROAD;
      end else if (!req_data.have_offset) begin
         entry.cls = CLS_NO_OFFSET;
      end else if (measured && (onset_fraction != 13'd0) &&
                   (req_data.real_distance != 16'd0)) begin
         entry.cls = CLS_MEASURED;
      end else begin
         entry.cls = CLS_CORRIDOR;
      end
   end

endmodule

FILE: hdl/epbs_queue.sv
// Short FIFO of classified entries between front and back.
module epbs_queue #(
   parameter int unsigned DEPTH = epbs_pkg::EPBS_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  epbs_pkg::entry_type push_entry,
   input  logic                pop,
   output epbs_pkg::entry_type head,
   output logic                full,
   output logic                empty
);
   import epbs_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hdl/epbs_back.sv
// Back end: grade computation, hysteresis, beep timer and result register.
module epbs_back (
   input  logic                clock,
   input  logic                reset,
   input  epbs_pkg::cfg_type   cfg,
   input  epbs_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output epbs_pkg::rsp_type   rsp_data
);
   import epbs_pkg::*;

   state_type          state_ff, state_in;
   entry_type          item_ff, item_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               holding_ff, holding_in;
   logic               approach_ff, approach_in;
   logic               gmeas_ff, gmeas_in;
   logic [15:0]        prev_ff, prev_in;
   logic [15:0]        armed_ff, armed_in;
   logic [10:0]        cd_ff, cd_in;

   logic [28:0]        om_ff, om_in;
   logic [31:0]        mc_ff, mc_in;
   logic signed [43:0] pm_ff, pm_in;
   logic [25:0]        ca_ff, ca_in;
   logic signed [43:0] p_ff, p_in;
   logic [38:0]        d_ff, d_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   dsh_ff, dsh_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic               ovf_ff, ovf_in;
   logic [15:0]        grade_ff, grade_in;
   logic [12:0]        n_ff, n_in;
   logic               surge_ff, surge_in;
   logic [23:0]        ia_ff, ia_in;
   logic [10:0]        intv_ff, intv_in;
   logic [9:0]         pitch_ff, pitch_in;

   logic               apply_active;
   logic               grade_changed;
   logic [15:0]        prev_eff;
   logic [16:0]        gdiff;
   logic signed [33:0] m_val;
   logic [43:0]        p_abs;
   logic               div_ge;
   logic [18:0]        ceil_q;
   logic [19:0]        neg_sum;
   logic [15:0]        n_diff;
   logic [20:0]        p300, p150;
   logic [24:0]        intv_sum;
   logic               sat, hold, do_beep;
   logic [15:0]        armed_t;
   logic [10:0]        t_raw, t_cap;

   assign pop       = (state_ff == ST_IDLE) && !empty && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Decisions for the datapath block; the hysteresis test is also used by the next-state block.
   always_comb begin
      grade_changed = (item_ff.measured != gmeas_ff);
      if (approach_ff) begin
         apply_active = (grade_ff >= GRADE_RELEASE);
      end else begin
         apply_active = (grade_ff >= GRADE_ONSET);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (item_ff.cls) inside
               CLS_OFF_ROAD, CLS_NO_OFFSET: state_in = ST_IDLE;
               CLS_CORRIDOR:                state_in = ST_APPLY;
               CLS_MEASURED:                state_in = ST_MUL_OM;
               default:                     state_in = ST_IDLE;
            endcase
         end
         ST_MUL_OM:   state_in = ST_MUL_MC;
         ST_MUL_MC:   state_in = ST_MUL_M;
         ST_MUL_M:    state_in = ST_MUL_CA;
         ST_MUL_CA:   state_in = ST_MUL_D;
         ST_MUL_D:    state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 5'd0) state_in = ST_GRADE;
         end
         ST_GRADE:    state_in = ST_APPLY;
         ST_APPLY:    state_in = apply_active ? ST_INTV_A : ST_IDLE;
         ST_INTV_A:   state_in = ST_INTV_B;
         ST_INTV_B:   state_in = ST_DECIDE;
         ST_DECIDE:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      holding_in   = holding_ff;
      approach_in  = approach_ff;
      gmeas_in     = gmeas_ff;
      prev_in      = prev_ff;
      armed_in     = armed_ff;
      cd_in        = cd_ff;
      om_in        = om_ff;
      mc_in        = mc_ff;
      pm_in        = pm_ff;
      ca_in        = ca_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      grade_in     = grade_ff;
      n_in         = n_ff;
      surge_in     = surge_ff;
      ia_in        = ia_ff;
      intv_in      = intv_ff;
      pitch_in     = pitch_ff;

      m_val    = $signed({6'd0, item_ff.real_distance, 12'd0}) - $signed({2'd0, mc_ff});
      p_abs    = p_ff[43] ? 44'(-p_ff) : 44'(p_ff);
      div_ge   = (rem_ff >= dsh_ff);
      ceil_q   = {1'b0, quo_ff} + {18'd0, (rem_ff != '0)};
      neg_sum  = 20'(GRADE_CEILING) + {1'b0, ceil_q};
      prev_eff = grade_changed ? grade_ff : prev_ff;
      gdiff    = {1'b0, grade_ff} - {1'b0, prev_eff};
      n_diff   = grade_ff - GRADE_ONSET;
      p300     = ({8'd0, n_ff} * 21'd300) + 21'd2048;
      p150     = ({8'd0, n_ff} * 21'd150) + 21'd2048;
      intv_sum = {1'b0, ia_ff} + ({14'd0, cfg.interval_near_ms} * {12'd0, n_ff})
                 + 25'd2048;
      sat      = (grade_ff >= GRADE_CEILING);
      hold     = sat && item_ff.no_tone_kind;
      if (({1'b0, grade_ff} + {1'b0, GRADE_STEP}) < {1'b0, armed_ff}) begin
         armed_t = (grade_ff > GRADE_ONSET) ? grade_ff : GRADE_ONSET;
      end else begin
         armed_t = armed_ff;
      end
      t_raw    = ({1'b0, item_ff.frame_ms} >= cd_ff) ? 11'd0
                                                    : cd_ff - {1'b0, item_ff.frame_ms};
      t_cap    = (t_raw > intv_ff) ? intv_ff : t_raw;
      do_beep  = !(((t_cap != 11'd0) && !surge_ff) ||
                   ((grade_ff < armed_t) && !surge_ff && !hold));

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) item_in = head;
         end
         ST_DISPATCH: begin
            unique case (item_ff.cls) inside
               CLS_OFF_ROAD: begin
                  rsp_in.tone_hold    = 1'b1;
                  rsp_in.tone_stop    = 1'b0;
                  rsp_in.beep         = 1'b0;
                  rsp_in.saw_wave     = item_ff.fall;
                  rsp_in.frequency_hz = item_ff.fall ? TONE_FALL_HZ : TONE_HZ;
                  rsp_in.pan          = item_ff.off_pan;
                  rsp_in.near_edge    = approach_ff;
                  rsp_valid_in        = 1'b1;
                  holding_in          = 1'b1;
               end
               CLS_NO_OFFSET: begin
                  rsp_in              = '0;
                  rsp_in.tone_stop    = holding_ff;
                  rsp_valid_in        = 1'b1;
                  holding_in          = 1'b0;
                  approach_in         = 1'b0;
               end
               CLS_CORRIDOR: begin
                  grade_in = (item_ff.mag > GRADE_CEILING) ? GRADE_CEILING : item_ff.mag;
               end
               default: begin
               end
            endcase
         end
         ST_MUL_OM: begin
            om_in = {16'd0, cfg.onset_fraction} * {13'd0, item_ff.real_distance};
         end
         ST_MUL_MC: begin
            mc_in = {16'd0, item_ff.mag} * {16'd0, item_ff.corridor};
         end
         ST_MUL_M: begin
            pm_in = 44'(m_val) * 44'sd1000;
         end
         ST_MUL_CA: begin
            ca_in = {11'd0, item_ff.closing_pos} * {15'd0, cfg.anticipation_ms};
         end
         ST_MUL_D: begin
            d_in = {10'd0, om_ff} * 39'd1000;
            p_in = pm_ff - $signed({6'd0, ca_ff, 12'd0});
         end
         ST_DIV_INIT: begin
            neg_in = p_ff[43];
            rem_in = {3'd0, p_abs[42:0], 11'd0};
            ovf_in = ({3'd0, p_abs[42:0], 11'd0} >= {d_ff, 18'd0});
            dsh_in = {1'b0, d_ff, 17'd0};
            quo_in = '0;
            cnt_in = 5'(QUO_W - 1);
         end
         ST_DIV: begin
            rem_in = div_ge ? rem_ff - dsh_ff : rem_ff;
            quo_in = {quo_ff[QUO_W-2:0], div_ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 5'd1;
         end
         ST_GRADE: begin
            // floor of a negative quotient is minus the rounded-up magnitude
            if (!neg_ff) begin
               grade_in = (ovf_ff || (quo_ff > QUO_W'(GRADE_CEILING))) ? 16'd0
                          : GRADE_CEILING - quo_ff[15:0];
            end else begin
               grade_in = (ovf_ff || (neg_sum > 20'd65535)) ? 16'hFFFF : neg_sum[15:0];
            end
         end
         ST_APPLY: begin
            gmeas_in = item_ff.measured;
            prev_in  = grade_ff;
            surge_in = approach_ff && !gdiff[16] && (gdiff[15:0] > GRADE_STEP);
            armed_in = grade_changed ? GRADE_ONSET : armed_ff;
            approach_in = apply_active;
            if (approach_ff) begin
               if (!apply_active) armed_in = GRADE_ONSET;
            end else if (apply_active) begin
               cd_in    = 11'd0;
               armed_in = GRADE_ONSET;
            end
            if (grade_ff <= GRADE_ONSET) begin
               n_in = 13'd0;
            end else if (grade_ff >= GRADE_CEILING) begin
               n_in = 13'd4096;
            end else begin
               n_in = {n_diff[11:0], 1'b0};
            end
            if (!apply_active) begin
               rsp_in           = '0;
               rsp_in.tone_stop = holding_ff;
               rsp_valid_in     = 1'b1;
               holding_in       = 1'b0;
            end
         end
         ST_INTV_A: begin
            ia_in    = {13'd0, cfg.interval_far_ms} * {11'd0, 13'd4096 - n_ff};
            pitch_in = item_ff.fall ? BEEP_FALL_HZ + 10'(p150[20:12])
                                    : BEEP_HZ + 10'(p300[20:12]);
         end
         ST_INTV_B: begin
            intv_in = intv_sum[22:12];
         end
         ST_DECIDE: begin
            rsp_in           = '0;
            rsp_in.tone_stop = holding_ff;
            rsp_in.near_edge = 1'b1;
            rsp_valid_in     = 1'b1;
            holding_in       = 1'b0;
            if (!sat || hold) begin
               if (do_beep) begin
                  armed_in            = grade_ff;
                  cd_in               = intv_ff;
                  rsp_in.beep         = 1'b1;
                  rsp_in.saw_wave     = item_ff.fall;
                  rsp_in.frequency_hz = pitch_ff;
                  rsp_in.pan          = item_ff.pan_right ? PAN_RIGHT : PAN_LEFT;
               end else begin
                  armed_in = armed_t;
                  cd_in    = t_cap;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         holding_ff   <= 1'b0;
         approach_ff  <= 1'b0;
         gmeas_ff     <= 1'b0;
         prev_ff      <= '0;
         armed_ff     <= GRADE_ONSET;
         cd_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         holding_ff   <= holding_in;
         approach_ff  <= approach_in;
         gmeas_ff     <= gmeas_in;
         prev_ff      <= prev_in;
         armed_ff     <= armed_in;
         cd_ff        <= cd_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      rsp_ff   <= rsp_in;
      om_ff    <= om_in;
      mc_ff    <= mc_in;
      pm_ff    <= pm_in;
      ca_ff    <= ca_in;
      p_ff     <= p_in;
      d_ff     <= d_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
      grade_ff <= grade_in;
      n_ff     <= n_in;
      surge_ff <= surge_in;
      ia_ff    <= ia_in;
      intv_ff  <= intv_in;
      pitch_ff <= pitch_in;
   end

endmodule

FILE: hdl/edge_proximity_beep_scheduler.sv
// Top level of the edge proximity beep scheduler: CSRs, front, queue and back.
// Accept to rsp_valid: off-road and no-offset frames answer from the dispatch state; the
// corridor grade passes the apply state and, if active, the interval and decide states; a
// measured grade first runs five multiply steps and an 18-bit restoring divider.
// Back end takes a frame only when idle with no result held; new frames queue meanwhile.
// Reset (synchronous, active high) restores CSR defaults, clears the queue and warning state.
module edge_proximity_beep_scheduler #(
   parameter int unsigned QUEUE_DEPTH = epbs_pkg::EPBS_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  epbs_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output epbs_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [epbs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [epbs_pkg::CSR_DATA_W-1:0]      csr_data
);
   import epbs_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      pop;
   logic      full;
   logic      empty;

   // CSR writes always taken: user must see that software writes only while block is idle.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ONSET_FRACTION: cfg_in.onset_fraction   = csr_data;
            CSR_ANTICIPATION:   cfg_in.anticipation_ms  = csr_data[10:0];
            CSR_INTERVAL_FAR:   cfg_in.interval_far_ms  = csr_data[10:0];
            CSR_INTERVAL_NEAR:  cfg_in.interval_near_ms = csr_data[10:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.onset_fraction   <= ONSET_FRACTION_RESET;
         cfg_ff.anticipation_ms  <= ANTICIPATION_RESET;
         cfg_ff.interval_far_ms  <= INTERVAL_FAR_RESET;
         cfg_ff.interval_near_ms <= INTERVAL_NEAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify each transaction on the way into the queue.
   epbs_front u_front (
      .req_valid      (req_valid),
      .req_data       (req_data),
      .req_stall      (req_stall),
      .onset_fraction (cfg_ff.onset_fraction),
      .queue_full     (full),
      .push           (push),
      .entry          (push_entry)
   );

   // Decouples front and back; transactions flow in while a grade is computed, until full.
   epbs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   // Back end: grade, hysteresis, beep timer; holds the result until taken.
   epbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/epbs_checker.sv
// Port-level checker for the edge proximity beep scheduler, with its bind.
module epbs_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input epbs_pkg::rsp_type rsp_data
);
   import epbs_pkg::*;

   a_reset_clears_rsp : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_tone_exclusive : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.tone_hold) |-> (!rsp_data.beep && !rsp_data.tone_stop))
      else $error("held tone combined with beep or stop");

   a_silent_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.tone_hold && !rsp_data.beep) |->
      (rsp_data.frequency_hz == 10'd0 && rsp_data.pan == PAN_CENTRE && !rsp_data.saw_wave))
      else $error("cue fields set without a cue");

   a_beep_near : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.beep) |-> rsp_data.near_edge)
      else $error("beep outside the approach state");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind edge_proximity_beep_scheduler epbs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
